/* hw/rtl/gh_thin_pkg.sv */
// shared types, constants and window functions for the thinning pass
`timescale 1ns / 1ps
package gh_thin_pkg;

  localparam int DefaultMaxWidth = 1024;
  localparam int CfgWidthW       = 11;
  localparam int CfgHeightW      = 16;
  localparam int CfgDataW        = 16;
  localparam int CfgIdxW         = 1;
  localparam int RowW            = CfgHeightW + 1;
  localparam int WidthReset      = 640;
  localparam int HeightReset     = 480;
  localparam int MinSize         = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } gh_cfg_idx_e;

  // one item entering a window stage
  typedef struct packed {
    logic valid;
    logic pix;
    logic interior;
  } gh_stage_req_t;

  // stage result for the item in its window center
  typedef struct packed {
    logic valid;
    logic pix;
    logic del;
  } gh_stage_rsp_t;

  // rows: bit1 two rows above, bit0 row above; window bit = row*3 + col, col 2 newest
  function automatic logic [8:0] gh_shift(logic [1:0] rows, logic [8:0] win, logic pix);
    gh_shift = {pix, win[8:7], rows[0], win[5:4], rows[1], win[2:1]};
  endfunction

  function automatic logic gh_delete(logic [8:0] win, logic iter);
    logic p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [3:0] trans;
    logic [2:0] n1, n2, nb;
    logic m;
    p9 = win[0]; p2 = win[1]; p3 = win[2];
    p8 = win[3]; p1 = win[4]; p4 = win[5];
    p7 = win[6]; p6 = win[7]; p5 = win[8];
    trans = 4'(!p2 && p3) + 4'(!p3 && p4) + 4'(!p4 && p5) + 4'(!p5 && p6)
          + 4'(!p6 && p7) + 4'(!p7 && p8) + 4'(!p8 && p9) + 4'(!p9 && p2);
    n1 = 3'(p2 | p3) + 3'(p4 | p5) + 3'(p6 | p7) + 3'(p8 | p9);
    n2 = 3'(p3 | p4) + 3'(p5 | p6) + 3'(p7 | p8) + 3'(p9 | p2);
    nb = (n1 < n2) ? n1 : n2;
    if (!iter) m = (p2 | p4 | !p6) & p8;
    else       m = (p4 | p6 | !p8) & p2;
    gh_delete = p1 && (trans == 4'd1) && (nb >= 3'd2) && (nb <= 3'd3) && !m;
  endfunction

endpackage

/* hw/rtl/gh_thin_stage.sv */
// one 3x3 window stage: line store, window register and deletion rule
`timescale 1ns / 1ps
module gh_thin_stage #(
  parameter int  Depth = 1024,
  parameter logic Iter = 1'b0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  gh_thin_pkg::gh_stage_req_t           req_i,
  input  logic [$clog2(Depth)-1:0]             addr_i,
  output gh_thin_pkg::gh_stage_rsp_t           rsp_o
);
  import gh_thin_pkg::*;

  localparam int AW = $clog2(Depth);

  logic [1:0]    mem [Depth];
  logic [1:0]    rd_q;
  logic [AW-1:0] addr_q;
  gh_stage_req_t item_q;
  logic [8:0]    win_q, win_d;
  logic [1:0]    wr_data;
  logic          del;

  assign win_d   = gh_shift(rd_q, win_q, item_q.pix);
  assign wr_data = {rd_q[0], item_q.pix};
  assign del     = item_q.interior && gh_delete(win_d, Iter);

  assign rsp_o.valid = item_q.valid;
  assign rsp_o.pix   = win_d[4] & !del;
  assign rsp_o.del   = item_q.valid & del;

  // line store: read for the incoming item, write back for the item in the window
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      addr_q <= addr_i;
      rd_q   <= mem[addr_i];
      if (item_q.valid) mem[addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
      win_q  <= '0;
    end else if (adv_i) begin
      item_q <= req_i;
      if (item_q.valid) win_q <= win_d;
    end
  end

endmodule

/* hw/rtl/guo_hall_thinning_pass.sv */
// Streaming thinning pass: one full thinning iteration over a raster-order binary image.
`timescale 1ns / 1ps
// Input channel (in_valid_i/in_ready_o) takes one item per transfer: req_type_i 0 is a pixel,
// 1 is a drain item; any nonzero pixel_value_i byte is foreground.
// Output channel (out_valid_o/out_ready_i) gives the thinned pixel, out_last_o on the last
// pixel of the frame and frame_changed_o there when any pixel was deleted in the frame.
// Two cascaded window stages each keep one line store of 2 bits per column, so the results
// trail the input by 2W+2 items; after the W*H pixels of a frame send 2W+2 drain items.
// The first 2W+2 transfers of a frame give no result.
// Throughput is one item per clock unless a held result stalls the pipeline; a result is
// registered in each window stage and then in the output register after its item's transfer.
// frame_width/frame_height are written on the cfg port while the block is idle; a write
// restarts the frame position but keeps line stores and windows.
// Reset clears the frame position and windows; line store contents are unknown until the
// first frame writes them, which only affects border pixels.
// When the receiver stalls with a result held, the pipeline and in_ready_o hold; items
// without a result keep moving.
module guo_hall_thinning_pass #(
  parameter int MaxWidth = gh_thin_pkg::DefaultMaxWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic [7:0]                       pixel_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_pixel_o,
  output logic                             out_last_o,
  output logic                             frame_changed_o,
  input  logic                             cfg_we_i,
  input  logic [gh_thin_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gh_thin_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import gh_thin_pkg::*;

  localparam int WW      = $clog2(MaxWidth + 1);
  localparam int CLW     = $clog2(MaxWidth);
  localparam int XW      = (WW > CfgWidthW) ? WW : CfgWidthW;
  localparam int ResetW  = (WidthReset > MaxWidth) ? MaxWidth : WidthReset;

  // frame geometry, stored already clamped
  logic [WW-1:0]         width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [XW-1:0]         wr_w;
  logic [WW-1:0]         wr_w_eff;
  logic [CfgHeightW-1:0] wr_h_eff;

  // input position in the frame
  logic [CLW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic           acc_q, acc_d;

  logic adv, accept, res_c;

  // geometry helpers
  logic [WW-1:0]   w_last;
  logic [RowW-1:0] h17, h_p1, h_p2;
  logic col_end, is_last, s1_act, s2_act, int1, int2, pix_in;
  logic [CLW-1:0] c2;

  // side info for the items in the two stages
  logic           b_s1_q, b_s2_q, b_int2_q, b_last_q;
  logic [CLW-1:0] b_c2_q;
  logic           c_valid_q, c_res_q, c_last_q, c_del1_q;

  gh_stage_req_t req1, req2;
  gh_stage_rsp_t rsp1, rsp2;

  logic out_valid_q, out_pix_q, out_last_q, out_chg_q;
  logic del_all;

  always_comb begin
    wr_w = XW'(cfg_wdata_i[CfgWidthW-1:0]);
    if (wr_w < XW'(MinSize))       wr_w_eff = WW'(MinSize);
    else if (wr_w > XW'(MaxWidth)) wr_w_eff = WW'(MaxWidth);
    else                           wr_w_eff = WW'(wr_w);
    if (cfg_wdata_i < CfgDataW'(MinSize)) wr_h_eff = CfgHeightW'(MinSize);
    else                                  wr_h_eff = cfg_wdata_i[CfgHeightW-1:0];
  end

  assign w_last  = width_q - WW'(1);
  assign h17     = RowW'(height_q);
  assign h_p1    = h17 + RowW'(1);
  assign h_p2    = h17 + RowW'(2);
  assign col_end = (WW'(col_q) == w_last);

  always_comb begin
    pix_in  = !req_type_i && (row_q < h17) && (pixel_value_i != 8'd0);
    s1_act  = (row_q >= RowW'(2)) || ((row_q == RowW'(1)) && (col_q != '0));
    s2_act  = (row_q >= RowW'(3)) || ((row_q == RowW'(2)) && (col_q >= CLW'(2)));
    int1    = (col_q >= CLW'(2)) && (row_q >= RowW'(2)) && (row_q < h17);
    // second stage center: one row and one column further back
    int2    = ((col_q == '0) && (row_q >= RowW'(4)) && (row_q <= h_p1))
           || ((col_q >= CLW'(3)) && (row_q >= RowW'(3)) && (row_q <= h17));
    is_last = (row_q == h_p2) && (col_q == CLW'(1));
    c2      = (col_q == '0) ? CLW'(w_last) : col_q - CLW'(1);
  end

  // pipeline only holds when a result meets a full output register
  assign res_c      = c_valid_q && c_res_q;
  assign adv        = !(res_c && out_valid_q && !out_ready_i);
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  assign req1.valid    = accept;
  assign req1.pix      = pix_in;
  assign req1.interior = int1;

  assign req2.valid    = rsp1.valid && b_s1_q;
  assign req2.pix      = rsp1.pix;
  assign req2.interior = b_int2_q;

  gh_thin_stage #(.Depth(MaxWidth), .Iter(1'b0)) u_stage0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .req_i  (req1),
    .addr_i (col_q),
    .rsp_o  (rsp1)
  );

  gh_thin_stage #(.Depth(MaxWidth), .Iter(1'b1)) u_stage1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .req_i  (req2),
    .addr_i (b_c2_q),
    .rsp_o  (rsp2)
  );

  assign del_all = c_del1_q | (rsp2.valid & rsp2.del);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    acc_d = acc_q;
    if (adv && c_valid_q) begin
      acc_d = c_last_q ? 1'b0 : (acc_q | del_all);
    end
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
      acc_d = 1'b0;
    end else if (accept) begin
      if (is_last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_end) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + CLW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(ResetW);
      height_q <= CfgHeightW'(HeightReset);
      col_q    <= '0;
      row_q    <= '0;
      acc_q    <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      acc_q <= acc_d;
      if (cfg_we_i) begin
        case (gh_cfg_idx_e'(cfg_idx_i))
          CFG_FRAME_WIDTH:  width_q  <= wr_w_eff;
          CFG_FRAME_HEIGHT: height_q <= wr_h_eff;
          default: ;
        endcase
      end
    end
  end

  // side info follows the items through both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= rsp1.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_s1_q   <= s1_act;
      b_s2_q   <= s2_act;
      b_int2_q <= int2;
      b_last_q <= is_last;
      b_c2_q   <= c2;
      c_res_q  <= b_s2_q;
      c_last_q <= b_last_q;
      c_del1_q <= rsp1.del;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res_c) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_c) begin
      out_pix_q  <= rsp2.pix;
      out_last_q <= c_last_q;
      out_chg_q  <= c_last_q & (acc_q | del_all);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_pixel_o     = out_pix_q;
  assign out_last_o      = out_last_q;
  assign frame_changed_o = out_chg_q;

endmodule

/* bench/tb.sv */
// testbench for guo_hall_thinning_pass: random frames checked against a pixel predictor
`timescale 1ns / 1ps
module tb;
  import gh_thin_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 500;
  localparam int IdlePct     = 38;
  localparam int HoldCycles  = 400;

  typedef struct packed {
    bit pix;
    bit last;
    bit changed;
  } thin_px_t;

  // tracks both sub-iterations and the frame position, queues expected output pixels
  class thin_scoreboard;
    bit [1:0]            sub0_rows [DefaultMaxWidth];
    bit [1:0]            sub1_rows [DefaultMaxWidth];
    bit [8:0]            sub0_win;
    bit [8:0]            sub1_win;
    bit [CfgWidthW-1:0]  width_reg;
    bit [CfgHeightW-1:0] height_reg;
    int unsigned         col, row, pos;
    bit                  any_deleted;
    thin_px_t            expected_px[$];
    int unsigned         inputs_seen, results_seen, errors;

    function new();
      width_reg  = CfgWidthW'(WidthReset);
      height_reg = CfgHeightW'(HeightReset);
      restart();
    endfunction

    function void restart();
      col = 0;
      row = 0;
      pos = 0;
      any_deleted = 1'b0;
    endfunction

    function int unsigned width_now();
      if (width_reg < MinSize) return MinSize;
      if (width_reg > DefaultMaxWidth) return DefaultMaxWidth;
      return width_reg;
    endfunction

    function int unsigned height_now();
      return (height_reg < MinSize) ? MinSize : height_reg;
    endfunction

    function int unsigned frame_items();
      return width_now() * height_now() + 2 * width_now() + 2;
    endfunction

    function void write_reg(gh_cfg_idx_e idx, bit [CfgDataW-1:0] data);
      if (idx == CFG_FRAME_WIDTH) width_reg = data[CfgWidthW-1:0];
      else height_reg = data;
      restart();
    endfunction

    // bit0 of a line store entry is the row above, bit1 two rows above
    function bit [8:0] shift_column(bit second, bit [8:0] win, int unsigned c, bit pix);
      bit [1:0] held;
      held = second ? sub1_rows[c] : sub0_rows[c];
      if (second) sub1_rows[c] = {held[0], pix};
      else sub0_rows[c] = {held[0], pix};
      return {pix, win[8:7], held[0], win[5:4], held[1], win[2:1]};
    endfunction

    function bit erodes(bit [8:0] win, bit second);
      bit n, ne, e, se, s, sw, w, nw, m;
      bit [7:0] ring;
      int trans, n1, n2, nb, k;
      nw = win[0]; n  = win[1]; ne = win[2];
      w  = win[3];              e  = win[5];
      sw = win[6]; s  = win[7]; se = win[8];
      if (!win[4]) return 1'b0;
      ring = {nw, w, sw, s, se, e, ne, n};
      trans = 0;
      for (k = 0; k < 8; k++) begin
        if (!ring[k] && ring[(k + 1) % 8]) trans++;
      end
      n1 = int'(n | ne) + int'(e | se) + int'(s | sw) + int'(w | nw);
      n2 = int'(ne | e) + int'(se | s) + int'(sw | w) + int'(nw | n);
      nb = (n1 < n2) ? n1 : n2;
      m = second ? ((e | s | !w) & n) : ((n | e | !s) & w);
      return trans == 1 && nb >= 2 && nb <= 3 && !m;
    endfunction

    function bit stage_pixel(bit [8:0] win, bit second, int unsigned r, int unsigned c,
                             int unsigned w, int unsigned h);
      if (r >= 1 && r <= h - 2 && c >= 1 && c <= w - 2 && erodes(win, second)) begin
        any_deleted = 1'b1;
        return 1'b0;
      end
      return win[4];
    endfunction

    function void note_input(bit drain, bit [7:0] value);
      int unsigned w, h, npix, last_pos, c2, r2, c3, r3;
      bit s1;
      thin_px_t px;
      w = width_now();
      h = height_now();
      npix = w * h;
      last_pos = npix + 2 * w + 1;
      inputs_seen++;
      // drain items inside the image read as background, pixels past it as drain
      sub0_win = shift_column(1'b0, sub0_win, col, !drain && pos < npix && value != 0);
      if (pos >= w + 1) begin
        if (col == 0) begin
          c2 = w - 1;
          r2 = row - 2;
        end else begin
          c2 = col - 1;
          r2 = row - 1;
        end
        s1 = stage_pixel(sub0_win, 1'b0, r2, c2, w, h);
        sub1_win = shift_column(1'b1, sub1_win, c2, s1);
        if (pos >= 2 * w + 2) begin
          c3 = (c2 == 0) ? w - 1 : c2 - 1;
          // row stays one above stage one even on the column wrap (border column anyway)
          r3 = r2 - 1;
          px.pix = stage_pixel(sub1_win, 1'b1, r3, c3, w, h);
          px.last = pos >= last_pos;
          px.changed = px.last && any_deleted;
          expected_px = {expected_px, px};
        end
      end
      if (pos >= last_pos) begin
        restart();
      end else begin
        pos++;
        col++;
        if (col >= w) begin
          col = 0;
          row++;
        end
      end
    endfunction

    function void check_result(logic pix, logic last, logic changed);
      thin_px_t want;
      results_seen++;
      if (expected_px.size() == 0) begin
        $error("unexpected output pixel: out_pixel %0d out_last %0d frame_changed %0d",
               pix, last, changed);
        errors++;
        return;
      end
      want = expected_px.pop_front();
      if (pix !== want.pix) begin
        $error("out_pixel: expected %0d, got %0d", want.pix, pix);
        errors++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0d, got %0d", want.last, last);
        errors++;
      end
      if (changed !== want.changed) begin
        $error("frame_changed: expected %0d, got %0d", want.changed, changed);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                req_type_i = 1'b0;
  logic [7:0]          pixel_value_i = 8'h00;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                out_pixel_o;
  logic                out_last_o;
  logic                frame_changed_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  thin_scoreboard sb;
  int unsigned    cycle_count;
  int unsigned    hold_left;
  bit             hold_req;
  bit             hold_done;

  guo_hall_thinning_pass u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .pixel_value_i   (pixel_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_pixel_o     (out_pixel_o),
    .out_last_o      (out_last_o),
    .frame_changed_o (frame_changed_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random backpressure, one long hold-off, and a stretch always ready
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (sb.results_seen >= 300 && sb.results_seen < 700) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= $urandom_range(99) >= IdlePct;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_pixel_o, out_last_o, frame_changed_o);
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(bit drain, bit [7:0] value);
    int gap_pct;
    gap_pct = (sb.inputs_seen >= 300 && sb.inputs_seen < 700) ? 0 : IdlePct;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= drain;
    pixel_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(drain, value);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_px.size() != 0) @(posedge clk_i);
    // items without a result may still be in the pipe
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure(bit [CfgDataW-1:0] width_val, bit [CfgDataW-1:0] height_val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_FRAME_WIDTH;
    cfg_wdata_i <= width_val;
    sb.write_reg(CFG_FRAME_WIDTH, width_val);
    @(negedge clk_i);
    cfg_idx_i <= CFG_FRAME_HEIGHT;
    cfg_wdata_i <= height_val;
    sb.write_reg(CFG_FRAME_HEIGHT, height_val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // count items from the start of a frame; noisy frames mix up the item kinds
  task automatic send_frame(int dens, bit noisy, int unsigned count, int hold_at = -1);
    int unsigned npix, i;
    bit drain;
    bit [7:0] value;
    npix = sb.width_now() * sb.height_now();
    for (i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i < npix) begin
        drain = noisy && $urandom_range(99) < 4;
        value = ($urandom_range(99) < dens) ? 8'($urandom_range(255, 1)) : 8'h00;
      end else begin
        drain = !(noisy && $urandom_range(99) < 15);
        value = 8'($urandom_range(255));
      end
      send_item(drain, value);
    end
  endtask

  task automatic run_phase();
    int unsigned total;
    configure(16'($urandom_range(12, 0)), 16'($urandom_range(10, 0)));
    total = sb.frame_items();
    repeat ($urandom_range(3, 1)) begin
      send_frame($urandom_range(85, 20), $urandom_range(3) == 0, total);
    end
    // sometimes cut a frame short so the next write restarts it
    if ($urandom_range(4) == 0) send_frame($urandom_range(85, 20), 1'b1,
                                           $urandom_range(total - 1, 1));
    wait_idle();
  endtask

  initial begin
    int unsigned start_count;
    sb = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 frame, both sizes below the minimum; center has N, NE and E set and erodes
    configure(16'd0, 16'd2);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h07);
    send_item(1'b1, 8'hFF);  // drain inside the image reads as background
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);  // pixel in the drain tail acts as drain
    repeat (7) send_item(1'b1, 8'h00);
    wait_idle();

    start_count = sb.inputs_seen;
    while (sb.inputs_seen - start_count < RandomItems) run_phase();

    // widest width (clamps to the line store depth), left unfinished
    configure(16'h07FF, 16'h0000);
    send_frame(50, 1'b0, 40);
    wait_idle();

    // tallest height with upper width bits masked off, left unfinished;
    // receiver holds off mid-frame
    configure(16'hF803, 16'hFFFF);
    send_frame(60, 1'b1, 50, 20);
    wait_idle();

    run_phase();

    if (sb.errors == 0 && sb.expected_px.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
